FILE: hdl/dttfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttfp_pkg
// shared types and constants for the decimal text to fixed point converter
// ----------------------------------------------------------------------------
package dttfp_pkg;

   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 48;
   localparam int STATUS_W = 2;

   // number of fraction weight table slots, indexed by the 4-bit digit position
   localparam int POS_W     = 4;
   localparam int POS_SLOTS = 16;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK  = 2'd0,
      STATUS_NAN = 2'd1,
      STATUS_SAT = 2'd2
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last_char;
   } char_item_type;

   // 10^n, evaluated at elaboration only
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

FILE: hdl/dttfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttfp channel interfaces
// valid/ready channels for characters in and fixed-point results out
// ----------------------------------------------------------------------------
interface dttfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last_char;

   modport source (output valid, output ch, output last_char, input ready);
   modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface dttfp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] value;
   logic [1:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: hdl/dttfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttfp_in_reg
// input register holding one character item ahead of the parse stage
// ----------------------------------------------------------------------------
module dttfp_in_reg
   import dttfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  char_item_type req_item,
   output logic          out_valid,
   output char_item_type out_item,
   input  logic          out_take
);

   logic          valid_ff;
   logic          valid_in;
   char_item_type item_ff;
   logic          accept;

   assign req_ready = !valid_ff || out_take;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept || (valid_ff && !out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: hdl/dttfp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttfp_parse
// per-character state update and registered fixed-point result
// ----------------------------------------------------------------------------
module dttfp_parse
   import dttfp_pkg::*;
#(
   parameter int FRAC_BITS       = 16,
   parameter int INT_BITS        = 31,
   parameter int MAX_FRAC_DIGITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  char_item_type      in_item,
   output logic               in_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_value,
   output status_type         rsp_status
);

   localparam int MAG_W  = INT_BITS + FRAC_BITS;
   localparam int WIDE_W = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;

   // floor(2^FRAC_BITS / 10^k) for digit position k = slot + 1
   logic [FRAC_BITS-1:0] weight_tab [POS_SLOTS];

   for (genvar k = 0; k < POS_SLOTS; k++) begin : g_weight
      localparam logic [63:0] WIDE =
         (k < MAX_FRAC_DIGITS) ? ((64'd1 << FRAC_BITS) / pow10(k + 1)) : 64'd0;
      assign weight_tab[k] = WIDE[FRAC_BITS-1:0];
   end

   logic                 first_ff,   first_in;
   logic                 neg_ff,     neg_in;
   logic                 in_frac_ff, in_frac_in;
   logic [INT_BITS-1:0]  int_ff,     int_in;
   logic [FRAC_BITS-1:0] frac_ff,    frac_in;
   logic [POS_W-1:0]     pos_ff,     pos_in;
   logic                 bad_ff,     bad_in;
   logic                 sat_ff,     sat_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   value_ff,     value_in;
   status_type           status_ff,    status_in;

   logic                 finish;
   logic [3:0]           digit;
   logic [INT_BITS+3:0]  int_next;
   logic [FRAC_BITS+3:0] frac_prod;
   logic [WIDE_W-1:0]    mag_wide;
   logic [VALUE_W-1:0]   mag;

   // a last character needs room in the result register
   assign in_take = in_valid && (!in_item.last_char || !rsp_valid_ff || rsp_ready);
   assign finish  = in_take && in_item.last_char;

   assign digit     = in_item.ch[3:0];
   assign int_next  = {1'b0, int_ff, 3'b000} + {3'b000, int_ff, 1'b0} +
                      {INT_BITS'(0), digit};
   assign frac_prod = {4'b0000, weight_tab[pos_ff]} * {FRAC_BITS'(0), digit};

   always_comb begin
      first_in   = 1'b0;
      neg_in     = neg_ff;
      in_frac_in = in_frac_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      pos_in     = pos_ff;
      bad_in     = bad_ff;
      sat_in     = sat_ff;

      if (first_ff && in_item.ch == CHAR_MINUS) begin
         neg_in = 1'b1;
      end else if (first_ff && in_item.ch == CHAR_PLUS) begin
         neg_in = neg_ff;
      end else if (in_item.ch == CHAR_POINT) begin
         in_frac_in = 1'b1;
      end else if (in_item.ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
         if (in_frac_ff) begin
            if (pos_ff < POS_W'(MAX_FRAC_DIGITS)) begin
               pos_in  = pos_ff + POS_W'(1);
               frac_in = frac_ff + frac_prod[FRAC_BITS-1:0];
            end
         end else if (|int_next[INT_BITS+3:INT_BITS]) begin
            int_in = '1;
            sat_in = 1'b1;
         end else begin
            int_in = int_next[INT_BITS-1:0];
         end
      end else begin
         bad_in = 1'b1;
      end
   end

   // magnitude wraps to the value field when the format is wider than it
   assign mag_wide = WIDE_W'({int_in, frac_in});
   assign mag      = mag_wide[VALUE_W-1:0];

   always_comb begin
      if (bad_in) begin
         value_in  = '0;
         status_in = STATUS_NAN;
      end else begin
         value_in  = neg_in ? (VALUE_W'(0) - mag) : mag;
         status_in = sat_in ? STATUS_SAT : STATUS_OK;
      end
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         first_ff   <= 1'b1;
         neg_ff     <= 1'b0;
         in_frac_ff <= 1'b0;
         int_ff     <= '0;
         frac_ff    <= '0;
         pos_ff     <= '0;
         bad_ff     <= 1'b0;
         sat_ff     <= 1'b0;
      end else if (in_take) begin
         first_ff   <= first_in;
         neg_ff     <= neg_in;
         in_frac_ff <= in_frac_in;
         int_ff     <= int_in;
         frac_ff    <= frac_in;
         pos_ff     <= pos_in;
         bad_ff     <= bad_in;
         sat_ff     <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

FILE: hdl/decimal_text_to_fixed_point_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top
// converts a stream of ascii decimal characters into signed fixed point
// ----------------------------------------------------------------------------
// One character is taken per item on req_chan; the character flagged with
// last_char closes the number and one result item with the signed value
// (INT_BITS integer bits, FRAC_BITS fraction bits, 48-bit two's complement
// field) and a status (ok, not a number, integer part saturated) follows on
// rsp_chan. A leading '-' negates, a leading '+' is skipped, the first '.'
// starts the fraction and later points are ignored; any other character makes
// the number not-a-number with value 0, though the text is still read to its
// last character. Fraction digits beyond MAX_FRAC_DIGITS add nothing. The
// block takes one character every clock cycle unless a waiting result holds a
// last character back: each character passes an input register and then a
// parse step (a multiply-by-ten add for integer digits, a table-weighted add
// for fraction digits) that updates the running state. The result is
// available on rsp_chan the cycle after the parse step of its last character.
// A result waiting in the output register blocks only the next last character;
// other characters keep flowing.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_top
   import dttfp_pkg::*;
#(
   parameter int FRAC_BITS       = 16,
   parameter int INT_BITS        = 31,
   parameter int MAX_FRAC_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   dttfp_req_if.sink   req_chan,
   dttfp_rsp_if.source rsp_chan
);

   // character item at the channel and in the input register
   char_item_type      req_item;
   char_item_type      stage_item;
   logic               stage_valid;
   logic               stage_take;
   logic [VALUE_W-1:0] rsp_value;
   status_type         rsp_status;

   assign req_item.ch        = req_chan.ch;
   assign req_item.last_char = req_chan.last_char;

   // input register, free to refill when empty or when the parse step takes its item
   dttfp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_item  (req_item),
      .out_valid (stage_valid),
      .out_item  (stage_item),
      .out_take  (stage_take)
   );

   // running number state and the result register
   dttfp_parse #(
      .FRAC_BITS       (FRAC_BITS),
      .INT_BITS        (INT_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid),
      .in_item    (stage_item),
      .in_take    (stage_take),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign rsp_chan.value  = $signed(rsp_value);
   assign rsp_chan.status = rsp_status;

endmodule

FILE: hdl/dttfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttfp_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module dttfp_checker
   import dttfp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [VALUE_W-1:0]  rsp_value,
   input logic [STATUS_W-1:0]        rsp_status
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

   // a not-a-number result carries a zero value
   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NAN) |-> (rsp_value == '0))
      else $error("not-a-number result with non-zero value");

   // status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NAN ||
                     rsp_status == STATUS_SAT))
      else $error("undefined status code");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value) && $stable(rsp_status)))
      else $error("stalled result item changed");

endmodule

bind decimal_text_to_fixed_point_top dttfp_checker u_dttfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value),
   .rsp_status (rsp_chan.status)
);
